FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms on clk_i with asynchronous reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GBR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/gbr_pkg.sv
// ----------------------------------------------------------------------------
// gbr_pkg
// Widths, register indexes and controller/datapath types of the burst
// ratchet generator.
// ----------------------------------------------------------------------------
package gbr_pkg;

  localparam int TIME_BITS     = 32;
  localparam int KNOB_BITS     = 12;
  localparam int PT_BITS       = 8;
  localparam int SCALE_BITS    = 4;
  localparam int CNT_BITS      = 5;
  localparam int PROD_BITS     = KNOB_BITS + SCALE_BITS;
  localparam int DIV_CNT_BITS  = $clog2(TIME_BITS + 1);
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 8;
  localparam int IN_TDATA_BITS  = ((1 + 3 * KNOB_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = 8;

  localparam logic [CFG_IDX_BITS-1:0] REG_PULSE_TICKS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BURST_SCALE = 2'd1;

  localparam logic [PT_BITS-1:0]    PT_RESET    = 8'd2;
  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 4'd10;

  // Commands from the controller, one step of the tick sequence each.
  typedef struct packed {
    logic load;     // capture the input word
    logic mult;     // knob times scale
    logic mark;     // edge detect, interval, burst count, start divider
    logic arm;      // arm burst, first pulse start
    logic arm_end;  // first pulse end
    logic win;      // window test and close handling
    logic send;     // rescheduled end, advance time, load result
  } gbr_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } gbr_status_t;

endpackage

FILE: design/gbr_div.sv
// ----------------------------------------------------------------------------
// gbr_div
// Restoring divider: time-wide dividend by a burst count, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module gbr_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [gbr_pkg::TIME_BITS-1:0]  dividend_i,
  input  logic [gbr_pkg::CNT_BITS-1:0]   divisor_i,
  output logic                           busy_o,
  output logic [gbr_pkg::TIME_BITS-1:0]  quotient_o
);
  import gbr_pkg::*;

  logic [TIME_BITS-1:0]    quo_q;
  logic [CNT_BITS-1:0]     rem_q;
  logic [CNT_BITS-1:0]     dsr_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic                    busy_q;

  logic [CNT_BITS:0] trial;
  logic [CNT_BITS:0] diff;
  logic              fits;

  assign trial = {rem_q, quo_q[TIME_BITS-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DIV_CNT_BITS'(TIME_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DIV_CNT_BITS'(1);
      if (cnt_q == DIV_CNT_BITS'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[TIME_BITS-2:0], fits};
      rem_q <= fits ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

FILE: design/gbr_datapath.sv
// ----------------------------------------------------------------------------
// gbr_datapath
// Tick state, burst schedule, configuration registers and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gbr_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gbr_pkg::gbr_cmd_t                   cmd_i,
  output gbr_pkg::gbr_status_t                status_o,
  input  logic [gbr_pkg::IN_TDATA_BITS-1:0]   in_data_i,
  input  logic                                cfg_valid_i,
  input  logic [gbr_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [gbr_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [gbr_pkg::OUT_TDATA_BITS-1:0]  out_data_o
);
  import gbr_pkg::*;

  // Configuration
  logic [PT_BITS-1:0]    pulse_ticks_q;
  logic [SCALE_BITS-1:0] burst_scale_q;

  // Captured word
  logic                 gate_q;
  logic [KNOB_BITS-1:0] chance_q;
  logic [KNOB_BITS-1:0] knob_q;
  logic [KNOB_BITS-1:0] rnd_q;

  // Per-tick working values
  logic [PROD_BITS-1:0] prod_q;
  logic [CNT_BITS-1:0]  count_q;
  logic                 arm_q;
  logic                 win_q;
  logic                 resched_q;

  // Architectural state
  logic [TIME_BITS-1:0] tick_q;
  logic [TIME_BITS-1:0] last_edge_q;
  logic [TIME_BITS-1:0] interval_q;
  logic [TIME_BITS-1:0] start_q;
  logic [TIME_BITS-1:0] end_q;
  logic                 armed_q;
  logic [CNT_BITS-1:0]  left_q;
  logic                 in_pulse_q;
  logic                 gate_prev_q;

  // Result register
  logic out_valid_q;
  logic gate_out_q;
  logic pulse_active_q;

  logic [PROD_BITS:0]   qsum;
  logic [CNT_BITS-1:0]  count_d;
  logic                 rising;
  logic [TIME_BITS-1:0] interval_new;
  logic [TIME_BITS-1:0] dividend;
  logic [TIME_BITS-1:0] quotient;
  logic                 div_busy;
  logic                 window;
  logic [CNT_BITS-1:0]  left_dec;
  logic [TIME_BITS-1:0] sched_start;
  logic [TIME_BITS-1:0] sched_end;

  // Divide by 2^KNOB_BITS - 1 as (p + (p >> KNOB_BITS) + 1) >> KNOB_BITS.
  assign qsum    = {1'b0, prod_q} + (PROD_BITS + 1)'(prod_q >> KNOB_BITS)
                   + (PROD_BITS + 1)'(1);
  assign count_d = CNT_BITS'(qsum[PROD_BITS:KNOB_BITS]) + CNT_BITS'(1);

  assign rising       = gate_q & ~gate_prev_q;
  assign interval_new = tick_q - last_edge_q;
  assign dividend     = rising ? interval_new : interval_q;

  assign sched_start = tick_q + quotient;
  assign sched_end   = start_q + TIME_BITS'(pulse_ticks_q);

  assign window   = armed_q && (tick_q > start_q) && (tick_q <= end_q);
  assign left_dec = (left_q != '0) ? left_q - CNT_BITS'(1) : left_q;

  gbr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mark),
    .dividend_i (dividend),
    .divisor_i  (count_d),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_ticks_q <= PT_RESET;
      burst_scale_q <= SCALE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PULSE_TICKS: pulse_ticks_q <= cfg_data_i[PT_BITS-1:0];
        REG_BURST_SCALE: burst_scale_q <= cfg_data_i[SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Word capture and scratch values: no reset needed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      gate_q   <= in_data_i[0];
      chance_q <= in_data_i[KNOB_BITS:1];
      knob_q   <= in_data_i[2*KNOB_BITS:KNOB_BITS+1];
      rnd_q    <= in_data_i[3*KNOB_BITS:2*KNOB_BITS+1];
    end
    if (cmd_i.mult) begin
      prod_q <= PROD_BITS'(knob_q) * PROD_BITS'(burst_scale_q);
    end
    if (cmd_i.mark) begin
      count_q <= count_d;
      arm_q   <= rising && (rnd_q > chance_q);
    end
    if (cmd_i.win) begin
      win_q <= window;
    end
    if (cmd_i.send) begin
      gate_out_q     <= gate_q | win_q;
      pulse_active_q <= win_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      last_edge_q <= '0;
      interval_q  <= '0;
      start_q     <= '0;
      end_q       <= '0;
      armed_q     <= 1'b0;
      left_q      <= '0;
      in_pulse_q  <= 1'b0;
      gate_prev_q <= 1'b0;
      resched_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.mark && rising) begin
        interval_q  <= interval_new;
        last_edge_q <= tick_q;
      end
      if (cmd_i.arm && arm_q) begin
        start_q <= sched_start;
        left_q  <= count_q - CNT_BITS'(1);
        armed_q <= 1'b1;
      end
      if (cmd_i.arm_end && arm_q) begin
        end_q <= sched_end;
      end
      if (cmd_i.win) begin
        resched_q <= 1'b0;
        if (window) begin
          in_pulse_q <= 1'b1;
        end else if (in_pulse_q) begin
          in_pulse_q <= 1'b0;
          left_q     <= left_dec;
          if (left_dec != '0) begin
            start_q   <= sched_start;
            resched_q <= 1'b1;
          end else begin
            armed_q <= 1'b0;
          end
        end
      end
      if (cmd_i.send) begin
        if (resched_q) begin
          end_q <= sched_end;
        end
        gate_prev_q <= gate_q;
        tick_q      <= tick_q + TIME_BITS'(1);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.div_busy = div_busy;
  assign status_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {(OUT_TDATA_BITS - 2)'(0), pulse_active_q, gate_out_q};

  `GBR_ASSERT_NEXT(a_count_nonzero, cmd_i.mark, count_q != '0, "burst count is zero")
  `GBR_ASSERT_NEXT(a_send_loads_out, cmd_i.send, out_valid_q, "result word not loaded")
  `GBR_ASSERT_NEXT(a_tick_holds, !cmd_i.send, $stable(tick_q), "tick moved outside send")
  `GBR_ASSERT_NOW(a_left_range, 1'b1, (left_q >> SCALE_BITS) == '0, "pulses left too big")

endmodule

FILE: design/gbr_ctrl.sv
// ----------------------------------------------------------------------------
// gbr_ctrl
// Sequencer that walks one tick through the datapath steps.
// ----------------------------------------------------------------------------
module gbr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  gbr_pkg::gbr_status_t  status_i,
  output gbr_pkg::gbr_cmd_t     cmd_o
);
  import gbr_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MULT    = 3'd1;
  localparam logic [2:0] ST_MARK    = 3'd2;
  localparam logic [2:0] ST_DIV     = 3'd3;
  localparam logic [2:0] ST_ARM     = 3'd4;
  localparam logic [2:0] ST_ARM_END = 3'd5;
  localparam logic [2:0] ST_WIN     = 3'd6;
  localparam logic [2:0] ST_SEND    = 3'd7;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = ST_MARK;
      end
      ST_MARK: begin
        cmd_o.mark = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        if (!status_i.div_busy) begin
          state_d = ST_ARM;
        end
      end
      ST_ARM: begin
        cmd_o.arm = 1'b1;
        state_d   = ST_ARM_END;
      end
      ST_ARM_END: begin
        cmd_o.arm_end = 1'b1;
        state_d       = ST_WIN;
      end
      ST_WIN: begin
        cmd_o.win = 1'b1;
        state_d   = ST_SEND;
      end
      ST_SEND: begin
        // hold until the result register is free
        if (status_i.out_free) begin
          cmd_o.send = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

FILE: design/gate_burst_ratchet_generator_top.sv
// ----------------------------------------------------------------------------
// gate_burst_ratchet_generator_top
// Gate burst ratchet generator: one input word per tick, one result word out.
// ----------------------------------------------------------------------------
// Each accepted word is one time tick. A rising gate edge measures the
// interval since the previous edge and, when random_value is above
// chance_knob, arms a burst of N = count_knob * burst_scale / 4095 + 1
// pulses spaced interval / N ticks apart, each pulse_ticks long. One result
// word comes back per input word: gate_out is the gate input OR the open
// pulse window, pulse_active flags the window. After a word is accepted, the
// steps run in order: multiply, edge and count, a wait on the bit-serial
// interval divider for all 32 quotient bits, then arm, pulse end, window test
// and result load, which holds until the result register is free. The next
// word is taken in the cycle after the result is loaded, even if that result
// still waits on m_axis_tready, so no word is taken while one is in progress.
// Configuration writes are taken every cycle and must only be issued while
// the block is idle; unknown register indexes are ignored.
// ----------------------------------------------------------------------------
module gate_burst_ratchet_generator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input word
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [0] gate_level, [12:1] chance_knob, [24:13] count_knob,
  // [36:25] random_value, [39:37] zero
  input  logic [gbr_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
  // result word
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] gate_out, [1] pulse_active, [7:2] zero
  output logic [gbr_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
  // register write: index 0 pulse_ticks, index 1 burst_scale
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gbr_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [gbr_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);
  import gbr_pkg::*;

  gbr_cmd_t    cmd;
  gbr_status_t status;

  // register writes never stall
  assign cfg_ready_o = 1'b1;

  gbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gbr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

FILE: tb/gate_burst_ratchet_generator_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gate_burst_ratchet_generator_top_test
// Self-checking bench for the gate burst ratchet generator.
// ----------------------------------------------------------------------------
// A queue of planned tick words and register writes feeds a clocked driver.
// Every accepted tick word is run through a local ratchet model, which pushes
// the gate_out / pulse_active pair it predicts. A clocked monitor pops one
// prediction per result word and compares it field by field. Both stream
// sides go quiet at random in runs of varying length, except for one calm
// stretch, and register writes are only issued once every predicted result
// has come back.
// ----------------------------------------------------------------------------
module gate_burst_ratchet_generator_top_test;
  import gbr_pkg::*;

  localparam int unsigned KNOB_FULL    = (1 << KNOB_BITS) - 1;
  localparam int          LIMIT_CYCLES = 1_500_000;
  localparam int          DRAIN_CYCLES = 64;   // a bit over one word's latency
  localparam int          CALM_FROM    = 15_000;
  localparam int          CALM_TO      = 27_000;
  localparam int          MAX_REPORTS  = 10;
  // no register sits at this index; writes to it must change nothing
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  // One tick word as packed on s_axis_tdata, gate_level in bit 0.
  typedef struct packed {
    logic [KNOB_BITS-1:0] random_value;
    logic [KNOB_BITS-1:0] count_knob;
    logic [KNOB_BITS-1:0] chance_knob;
    logic                 gate_level;
  } tick_word_t;

  // One result word as packed on m_axis_tdata, gate_out in bit 0.
  typedef struct packed {
    logic pulse_active;
    logic gate_out;
  } gate_result_t;

  typedef enum logic {PLAN_TICK, PLAN_REG} plan_kind_e;

  typedef struct {
    plan_kind_e                kind;
    tick_word_t                word;
    logic [CFG_IDX_BITS-1:0]   idx;
    logic [CFG_DATA_BITS-1:0]  data;
  } plan_entry_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block I/O. Every input holds a known value from time 0.
  // --------------------------------------------------------------------------
  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [IN_TDATA_BITS-1:0]   s_axis_tdata  = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0]  m_axis_tdata;
  logic                       cfg_valid_i   = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]    cfg_index_i   = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_data_i    = '0;

  gate_burst_ratchet_generator_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  plan_entry_t  tick_plan_q[$];     // words and register writes still to send
  gate_result_t gate_expect_q[$];   // predicted results, oldest first
  int           planned_ticks = 0;
  int           miss_cnt      = 0;
  int           cyc_cnt       = 0;
  logic         src_idle      = 1'b0;

  // --------------------------------------------------------------------------
  // Ratchet model: registers and tick state, all at the block's widths.
  // Times wrap modulo 2^TIME_BITS just as in the block.
  // --------------------------------------------------------------------------
  logic [PT_BITS-1:0]    len_cfg     = PT_RESET;
  logic [SCALE_BITS-1:0] scale_cfg   = SCALE_RESET;
  logic [TIME_BITS-1:0]  now_r       = '0;
  logic [TIME_BITS-1:0]  edge_time_r = '0;
  logic [TIME_BITS-1:0]  edge_gap_r  = '0;
  logic [TIME_BITS-1:0]  win_lo_r    = '0;
  logic [TIME_BITS-1:0]  win_hi_r    = '0;
  logic                  armed_r     = 1'b0;
  logic [CNT_BITS-1:0]   remain_r    = '0;
  logic                  open_r      = 1'b0;
  logic                  gate_d_r    = 1'b0;

  // Open the next pulse window gap/n ticks from now, len_cfg ticks long.
  function automatic void place_window(input logic [CNT_BITS-1:0] n);
    win_lo_r = now_r + edge_gap_r / TIME_BITS'(n);
    win_hi_r = win_lo_r + TIME_BITS'(len_cfg);
  endfunction

  // Advance the model by one tick and return the result word it predicts.
  function automatic gate_result_t ratchet_tick(input tick_word_t w);
    logic [CNT_BITS-1:0] n;
    logic                window;
    gate_result_t        r;
    // burst size from the knob as it stands on this tick, 1..16
    n = CNT_BITS'((32'(w.count_knob) * 32'(scale_cfg)) / KNOB_FULL + 1);
    if (w.gate_level && !gate_d_r) begin
      edge_gap_r  = now_r - edge_time_r;
      edge_time_r = now_r;
      // a losing roll leaves any running burst alone
      if (w.random_value > w.chance_knob) begin
        remain_r = n - 1'b1;
        place_window(n);
        armed_r  = 1'b1;
      end
    end
    window = armed_r && now_r > win_lo_r && now_r <= win_hi_r;
    if (window) begin
      open_r = 1'b1;
    end else if (open_r) begin
      // first tick after a window: count it, then reschedule or disarm
      open_r = 1'b0;
      if (remain_r != '0) remain_r--;
      if (remain_r != '0) place_window(n);
      else armed_r = 1'b0;
    end
    gate_d_r       = w.gate_level;
    now_r          = now_r + 1'b1;
    r.gate_out     = w.gate_level | window;
    r.pulse_active = window;
    return r;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_PULSE_TICKS: begin
        len_cfg = data[PT_BITS-1:0];
      end
      REG_BURST_SCALE: begin
        scale_cfg = data[SCALE_BITS-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Plan builders
  // --------------------------------------------------------------------------
  function automatic void push_tick(input bit g, input int unsigned chance,
                                    input int unsigned knob, input int unsigned roll);
    plan_entry_t e;
    e.kind                = PLAN_TICK;
    e.word.gate_level     = g;
    e.word.chance_knob    = KNOB_BITS'(chance);
    e.word.count_knob     = KNOB_BITS'(knob);
    e.word.random_value   = KNOB_BITS'(roll);
    e.idx                 = '0;
    e.data                = '0;
    tick_plan_q.push_back(e);
    planned_ticks++;
  endfunction

  function automatic void push_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                   input logic [CFG_DATA_BITS-1:0] data);
    plan_entry_t e;
    e.kind = PLAN_REG;
    e.word = '0;
    e.idx  = idx;
    e.data = data;
    tick_plan_q.push_back(e);
  endfunction

  // Random gate trains until the tick count reaches goal. Most of it is
  // regular clock patterns with a steady knob and a mostly winning roll on
  // each rising edge; the rest is raw noise that breaks the patterns.
  // Stop right at goal, even in the middle of a pattern.
  function automatic void push_trains(input int goal);
    int unsigned period, high_len, reps, chance, knob, roll, burst;
    while (planned_ticks < goal) begin
      if ($urandom_range(99) < 15) begin
        burst = $urandom_range(20, 1);
        repeat (burst) begin
          if (planned_ticks >= goal) break;
          push_tick($urandom_range(1), $urandom_range(KNOB_FULL),
                    $urandom_range(KNOB_FULL), $urandom_range(KNOB_FULL));
        end
      end else begin
        period   = ($urandom_range(9) == 0) ? $urandom_range(300, 60)
                                            : $urandom_range(40, 2);
        high_len = $urandom_range(period - 1, 1);
        reps     = $urandom_range(5, 2);
        knob     = $urandom_range(KNOB_FULL);
        chance   = $urandom_range(KNOB_FULL);
        repeat (reps) begin
          for (int t = 0; t < period; t++) begin
            if (planned_ticks >= goal) break;
            roll = $urandom_range(KNOB_FULL);
            if (t == 0 && $urandom_range(99) < 75) begin
              // make the roll win on this edge
              chance = $urandom_range(KNOB_FULL - 1);
              roll   = $urandom_range(KNOB_FULL, chance + 1);
            end
            if ($urandom_range(99) < 3) knob = $urandom_range(KNOB_FULL);
            push_tick(t < high_len, chance, knob, roll);
          end
        end
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Idle chains: each side drops out in runs of varying length, about a third
  // of the time overall, so gaps land on every stage of a word's processing.
  // Hold both sides busy during the calm stretch.
  // --------------------------------------------------------------------------
  function automatic logic next_idle(input logic cur, input logic calm);
    if (calm) return 1'b0;
    if (cur) return $urandom_range(9999) >= 300;
    return $urandom_range(9999) < 155;
  endfunction

  always @(posedge clk_i) begin : idle_chains
    logic calm;
    calm = cyc_cnt >= CALM_FROM && cyc_cnt < CALM_TO;
    if (rst_ni) begin
      src_idle      <= next_idle(src_idle, calm);
      m_axis_tready <= !next_idle(!m_axis_tready, calm);
    end
  end

  // --------------------------------------------------------------------------
  // Driver: retire the words accepted at this edge, then present the next
  // plan entry. A register write waits until every predicted result is back,
  // so it only reaches an idle block. Each output gets one assignment per edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : tick_driver
    logic        word_v;
    logic        reg_v;
    plan_entry_t head;
    word_v = s_axis_tvalid;
    reg_v  = cfg_valid_i;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        gate_expect_q.push_back(
          ratchet_tick(tick_word_t'(s_axis_tdata[$bits(tick_word_t)-1:0])));
        word_v = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        apply_reg(cfg_index_i, cfg_data_i);
        reg_v = 1'b0;
      end
      if (!word_v && !reg_v && tick_plan_q.size() != 0) begin
        head = tick_plan_q[0];
        if (head.kind == PLAN_TICK) begin
          if (!src_idle) begin
            void'(tick_plan_q.pop_front());
            word_v = 1'b1;
            s_axis_tdata <= IN_TDATA_BITS'(head.word);
          end
        end else if (gate_expect_q.size() == 0) begin
          void'(tick_plan_q.pop_front());
          reg_v = 1'b1;
          cfg_index_i <= head.idx;
          cfg_data_i  <= head.data;
        end
      end
      s_axis_tvalid <= word_v;
      cfg_valid_i   <= reg_v;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each accepted result word against the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic flag_miss(input string what, input logic want, input logic got);
    miss_cnt++;
    if (miss_cnt <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %b, got %b", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    gate_result_t got;
    gate_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = gate_result_t'(m_axis_tdata[$bits(gate_result_t)-1:0]);
      if (gate_expect_q.size() == 0) begin
        // nothing predicted: a stray word is a failure on its own
        flag_miss("unexpected result word, gate_out", 1'bx, got.gate_out);
      end else begin
        want = gate_expect_q.pop_front();
        if (got.gate_out !== want.gate_out)
          flag_miss("gate_out", want.gate_out, got.gate_out);
        if (got.pulse_active !== want.pulse_active)
          flag_miss("pulse_active", want.pulse_active, got.pulse_active);
      end
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus plan, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    // Directed opening under the reset settings (2-tick pulses, scale 10).
    push_tick(0, 0, 0, 0);
    push_tick(0, KNOB_FULL, KNOB_FULL, KNOB_FULL);
    push_tick(1, 0, KNOB_FULL, KNOB_FULL);            // edge, arm a full burst
    push_tick(1, KNOB_FULL, KNOB_FULL, 0);
    push_tick(0, KNOB_FULL, KNOB_FULL, 0);
    push_tick(0, 0, KNOB_FULL, 0);
    push_tick(1, 2048, KNOB_FULL, 2048);              // roll equals chance: no arm
    push_tick(0, 2048, KNOB_FULL, 2048);
    push_tick(0, 2048, KNOB_FULL, 2048);
    push_tick(1, KNOB_FULL, 0, KNOB_FULL - 1);        // roll below chance
    push_tick(0, KNOB_FULL, 0, 0);
    push_tick(0, KNOB_FULL, 0, 0);
    push_tick(1, 0, 0, 1);                            // single-pulse burst
    push_tick(0, 0, 0, 0);
    push_tick(0, 0, 0, 0);
    push_tick(0, 0, 0, 0);
    push_tick(0, 0, 0, 0);
    push_tick(1, 100, 2048, KNOB_FULL);               // six-pulse burst
    push_tick(0, 100, 2048, 0);
    push_tick(0, 100, 2048, 0);
    push_tick(1, 0, KNOB_FULL, 1);                    // rearm mid-burst
    push_tick(1, 0, KNOB_FULL, 0);
    push_tick(0, 0, KNOB_FULL, 0);
    push_tick(0, 0, KNOB_FULL, 0);
    push_tick(0, 0, KNOB_FULL, 0);

    // Random phases, each under its own register setting.
    push_trains(300);
    push_reg(REG_PULSE_TICKS, 8'd1);
    push_reg(REG_BURST_SCALE, 8'hFF);                  // upper bits dropped: 15
    push_trains(580);
    push_reg(REG_PULSE_TICKS, 8'd255);
    push_reg(REG_BURST_SCALE, 8'd0);
    push_trains(840);
    push_reg(REG_PULSE_TICKS, 8'd0);                   // empty windows
    push_reg(REG_BURST_SCALE, 8'd7);
    push_reg(REG_SPARE, 8'hA5);
    push_trains(1000);
    push_reg(REG_PULSE_TICKS, 8'd5);
    push_reg(REG_BURST_SCALE, 8'h13);                  // scale 3
    push_trains(1330);
    push_reg(REG_PULSE_TICKS, 8'd3);
    push_reg(REG_BURST_SCALE, 8'd15);
    push_trains(1650);

    // Hold reset, then release it at a rising edge.
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait out the plan and every outstanding prediction, then drain.
    while (tick_plan_q.size() != 0 || s_axis_tvalid || cfg_valid_i ||
           gate_expect_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (miss_cnt == 0 && gate_expect_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
